@@ rtl/core/omni_wheel_mixer_pwm_unit_assert.svh @@
// Assertion macros shared by the omni-wheel mixer RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef OMNI_WHEEL_MIXER_PWM_UNIT_ASSERT_SVH
`define OMNI_WHEEL_MIXER_PWM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OMW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omw: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OMW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("omw: next-cycle check failed");

`endif

@@ rtl/core/omw_pkg.sv @@
// Package of the omni-wheel mixer: constants, register codes, sine table.
// Used by the wheel lane and the top level.
`timescale 1ns / 1ps

package omw_pkg;

  // Sine precision and derived rounding constants.
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_W         = SINE_FRAC_BITS + 1;
  localparam int SINE_SHIFT     = 16 - SINE_FRAC_BITS;
  localparam int SINE_HALF      = (1 << SINE_SHIFT) >> 1;

  // Pipeline depth of a wheel lane.
  localparam int NUM_STAGES = 7;
  localparam int NUM_WHEELS = 4;

  // Angle arithmetic.
  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_3QUART  = 270;

  // Scaling: pwm = |m * gain| * 255 / 25600, split as (x*255 >> 8) / 100.
  localparam int DUTY_MAX     = 255;
  localparam int CLAMP_Q      = 25600;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_WHEEL1_ANGLE = 3'd0,
    REG_WHEEL2_ANGLE = 3'd1,
    REG_WHEEL3_ANGLE = 3'd2,
    REG_WHEEL4_ANGLE = 3'd3,
    REG_WHEEL1_GAIN  = 3'd4,
    REG_WHEEL2_GAIN  = 3'd5,
    REG_WHEEL3_GAIN  = 3'd6,
    REG_WHEEL4_GAIN  = 3'd7
  } cfg_reg_t;

  localparam logic [8:0] ANGLE_RESET [NUM_WHEELS] = '{9'd45, 9'd135, 9'd225, 9'd315};
  localparam logic [9:0] GAIN_RESET = 10'd256;

  // Stage load enables handed from the flow control to every lane.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } lane_ctl_t;

  // Quarter-wave sine per degree, Q1.16.
  localparam logic [16:0] QSINE_Q16 [91] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Sine magnitude at SINE_FRAC_BITS fraction bits, rounded half up.
  function automatic logic [SINE_W-1:0] sine_mag(input logic [6:0] idx);
    logic [17:0] sum;
    sum = {1'b0, QSINE_Q16[idx]} + 18'(SINE_HALF);
    return SINE_W'(sum >> SINE_SHIFT);
  endfunction

endpackage

@@ rtl/core/omw_if.sv @@
// Request channels of the omni-wheel mixer: commands in, duty pairs out.
// Depends on nothing but the language; used by the top level.
`timescale 1ns / 1ps

interface omw_cmd_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic signed [9:0] heading;
  logic              translate_enable;
  logic [6:0]        speed;
  logic signed [7:0] rotation;
  logic signed [8:0] direct_speed_1;
  logic signed [8:0] direct_speed_2;
  logic signed [8:0] direct_speed_3;
  logic signed [8:0] direct_speed_4;

  modport source (
    output valid, operation, heading, translate_enable, speed, rotation,
           direct_speed_1, direct_speed_2, direct_speed_3, direct_speed_4,
    input  ready
  );
  modport sink (
    input  valid, operation, heading, translate_enable, speed, rotation,
           direct_speed_1, direct_speed_2, direct_speed_3, direct_speed_4,
    output ready
  );
endinterface

interface omw_duty_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_1a;
  logic [7:0] duty_1b;
  logic [7:0] duty_2a;
  logic [7:0] duty_2b;
  logic [7:0] duty_3a;
  logic [7:0] duty_3b;
  logic [7:0] duty_4a;
  logic [7:0] duty_4b;

  modport source (
    output valid, duty_1a, duty_1b, duty_2a, duty_2b, duty_3a, duty_3b,
           duty_4a, duty_4b,
    input  ready
  );
  modport sink (
    input  valid, duty_1a, duty_1b, duty_2a, duty_2b, duty_3a, duty_3b,
           duty_4a, duty_4b,
    output ready
  );
endinterface

@@ rtl/core/omw_lane.sv @@
// One wheel of the mixer: seven-stage datapath from command to duty pair.
// Depends on omw_pkg; stage loads come from the flow control in the top level.
`timescale 1ns / 1ps

module omw_lane (
  input  logic              clk,
  input  omw_pkg::lane_ctl_t ctl,
  input  logic              operation,
  input  logic signed [9:0] heading,
  input  logic              translate_enable,
  input  logic [6:0]        speed,
  input  logic signed [7:0] rotation,
  input  logic signed [8:0] direct_speed,
  input  logic [8:0]        angle,
  input  logic [9:0]        gain,
  output logic [7:0]        duty_a,
  output logic [7:0]        duty_b
);

  // Stage 1 registers: angle difference reduced into 0..359.
  logic [8:0]        d1_r, d1_nxt;
  logic              op1_r, tr1_r;
  logic [6:0]        spd1_r;
  logic signed [7:0] rot1_r;
  logic signed [8:0] dir1_r;

  // Stage 2 registers: sine magnitude and sign.
  logic [omw_pkg::SINE_W-1:0] s2_r, s2_nxt;
  logic              neg2_r, neg2_nxt;
  logic              op2_r, tr2_r;
  logic [6:0]        spd2_r;
  logic signed [7:0] rot2_r;
  logic signed [8:0] dir2_r;

  // Stage 3 registers: truncated translation term.
  logic [6:0]        t3_r, t3_nxt;
  logic              neg3_r, op3_r, tr3_r;
  logic signed [7:0] rot3_r;
  logic signed [8:0] dir3_r;

  // Stage 4 to 6 registers.
  logic signed [9:0]  wheel4_r, wheel4_nxt;
  logic signed [20:0] p5_r, p5_nxt;
  logic [14:0]        q6_r, q6_nxt;
  logic               big6_r, big6_nxt;
  logic               pos6_r, pos6_nxt;

  // Stage 7 (output) registers.
  logic [7:0] duty_a_r, duty_a_nxt;
  logic [7:0] duty_b_r, duty_b_nxt;

  // Combinational helpers.
  logic signed [11:0] diff;
  logic [10:0]        wrap;
  logic [6:0]         idx;
  logic [omw_pkg::SINE_W+6:0] tprod;
  logic signed [9:0]  tsig;
  logic [19:0]        absval;
  logic [27:0]        scaled;
  logic [19:0]        q;
  logic [27:0]        dprod;
  logic [7:0]         mag;

  // Stage 1: offset the difference to a positive value and fold it below 360.
  always_comb begin
    diff = 12'(heading) - $signed({3'b000, angle}) + 12'sd1080;
    wrap = diff[10:0];
    if (wrap >= 11'(omw_pkg::DEG_FULL * 4)) begin
      wrap = wrap - 11'(omw_pkg::DEG_FULL * 4);
    end else if (wrap >= 11'(omw_pkg::DEG_FULL * 3)) begin
      wrap = wrap - 11'(omw_pkg::DEG_FULL * 3);
    end else if (wrap >= 11'(omw_pkg::DEG_FULL * 2)) begin
      wrap = wrap - 11'(omw_pkg::DEG_FULL * 2);
    end else if (wrap >= 11'(omw_pkg::DEG_FULL)) begin
      wrap = wrap - 11'(omw_pkg::DEG_FULL);
    end
    d1_nxt = wrap[8:0];
  end

  // Stage 2: fold into the first quadrant and look up the sine.
  always_comb begin
    if (d1_r <= 9'(omw_pkg::DEG_QUARTER)) begin
      idx      = d1_r[6:0];
      neg2_nxt = 1'b0;
    end else if (d1_r <= 9'(omw_pkg::DEG_HALF)) begin
      idx      = 7'(9'(omw_pkg::DEG_HALF) - d1_r);
      neg2_nxt = 1'b0;
    end else if (d1_r <= 9'(omw_pkg::DEG_3QUART)) begin
      idx      = 7'(d1_r - 9'(omw_pkg::DEG_HALF));
      neg2_nxt = 1'b1;
    end else begin
      idx      = 7'(9'(omw_pkg::DEG_FULL) - d1_r);
      neg2_nxt = 1'b1;
    end
    s2_nxt = omw_pkg::sine_mag(idx);
  end

  // Stage 3: sine times speed, truncated toward zero on the magnitude.
  always_comb begin
    tprod  = s2_r * spd2_r;
    t3_nxt = 7'(tprod >> omw_pkg::SINE_FRAC_BITS);
  end

  // Stage 4: pick the wheel speed for the command type.
  always_comb begin
    tsig = neg3_r ? -$signed({3'b000, t3_r}) : $signed({3'b000, t3_r});
    if (op3_r) begin
      wheel4_nxt = 10'(dir3_r);
    end else if (!tr3_r) begin
      wheel4_nxt = 10'(rot3_r);
    end else begin
      wheel4_nxt = tsig + 10'(rot3_r);
    end
  end

  // Stage 5: apply the wheel gain.
  always_comb begin
    p5_nxt = wheel4_r * $signed({1'b0, gain});
  end

  // Stage 6: magnitude times 255 over 256, with the clamp decided early.
  always_comb begin
    absval   = p5_r[20] ? 20'(-p5_r) : p5_r[19:0];
    scaled   = absval * 28'(omw_pkg::DUTY_MAX);
    q        = scaled[27:8];
    big6_nxt = q >= 20'(omw_pkg::CLAMP_Q);
    q6_nxt   = q[14:0];
    pos6_nxt = !p5_r[20] && (p5_r != '0);
  end

  // Stage 7: divide by 100 through a reciprocal, clamp and encode the pair.
  always_comb begin
    dprod = q6_r * 13'(omw_pkg::DIV100_MUL);
    mag   = big6_r ? 8'(omw_pkg::DUTY_MAX) : 8'(dprod >> omw_pkg::DIV100_SHIFT);
    if (pos6_r && (mag != '0)) begin
      duty_a_nxt = 8'(omw_pkg::DUTY_MAX) - mag;
      duty_b_nxt = 8'(omw_pkg::DUTY_MAX);
    end else begin
      duty_a_nxt = 8'(omw_pkg::DUTY_MAX);
      duty_b_nxt = 8'(omw_pkg::DUTY_MAX) - mag;
    end
  end

  // Stage registers; each loads when its stage advances.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      d1_r   <= d1_nxt;
      op1_r  <= operation;
      tr1_r  <= translate_enable;
      spd1_r <= speed;
      rot1_r <= rotation;
      dir1_r <= direct_speed;
    end
    if (ctl.load[1]) begin
      s2_r   <= s2_nxt;
      neg2_r <= neg2_nxt;
      op2_r  <= op1_r;
      tr2_r  <= tr1_r;
      spd2_r <= spd1_r;
      rot2_r <= rot1_r;
      dir2_r <= dir1_r;
    end
    if (ctl.load[2]) begin
      t3_r   <= t3_nxt;
      neg3_r <= neg2_r;
      op3_r  <= op2_r;
      tr3_r  <= tr2_r;
      rot3_r <= rot2_r;
      dir3_r <= dir2_r;
    end
    if (ctl.load[3]) begin
      wheel4_r <= wheel4_nxt;
    end
    if (ctl.load[4]) begin
      p5_r <= p5_nxt;
    end
    if (ctl.load[5]) begin
      q6_r   <= q6_nxt;
      big6_r <= big6_nxt;
      pos6_r <= pos6_nxt;
    end
    if (ctl.load[6]) begin
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
    end
  end

  assign duty_a = duty_a_r;
  assign duty_b = duty_b_r;

endmodule

@@ rtl/core/omni_wheel_mixer_pwm_unit.sv @@
// Top level of the omni-wheel mixer: register file, flow control, four lanes.
// Depends on omw_pkg, omw_if, omw_lane and the assertion macro header.
`timescale 1ns / 1ps
`include "omni_wheel_mixer_pwm_unit_assert.svh"

// Four-wheel omni-drive mixer. Each request on in_cmd is either a heading
// command (heading, speed, rotation) or four direct wheel speeds, and yields
// one request on out_duty carrying two active-low duty values per wheel.
// The four wheels run in parallel lanes of seven register stages each
// (angle reduction, sine lookup, speed product, wheel sum, gain product,
// scaling, divide-clamp-encode), and the last stage drives out_duty.
// One command is taken every cycle while out_duty is ready. Every stage
// holds its own valid bit and only stalls when the stage after it is full
// and cannot advance, so holes in the pipeline close up while out_duty is
// not ready. Mounting angles and gains sit in an APB register file at byte
// address 4*i; write them only while no command is in flight.
module omni_wheel_mixer_pwm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  omw_cmd_if.sink                        in_cmd,
  omw_duty_if.source                     out_duty,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [omw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [omw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [omw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int NS = omw_pkg::NUM_STAGES;
  localparam int NW = omw_pkg::NUM_WHEELS;

  logic [8:0] angle_r [NW];
  logic [9:0] gain_r  [NW];

  logic              cfg_wr;
  omw_pkg::cfg_reg_t cfg_idx;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS-1:0] adv;
  omw_pkg::lane_ctl_t ctl;

  logic signed [8:0] direct [NW];
  logic [7:0]        duty_a [NW];
  logic [7:0]        duty_b [NW];

  // Register file write: on an access with all strobes high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = omw_pkg::cfg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) begin
        angle_r[i] <= omw_pkg::ANGLE_RESET[i];
        gain_r[i]  <= omw_pkg::GAIN_RESET;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        omw_pkg::REG_WHEEL1_ANGLE, omw_pkg::REG_WHEEL2_ANGLE,
        omw_pkg::REG_WHEEL3_ANGLE, omw_pkg::REG_WHEEL4_ANGLE: begin
          angle_r[cfg_idx[1:0]] <= cfg_pwdata[8:0];
        end
        omw_pkg::REG_WHEEL1_GAIN, omw_pkg::REG_WHEEL2_GAIN,
        omw_pkg::REG_WHEEL3_GAIN, omw_pkg::REG_WHEEL4_GAIN: begin
          gain_r[cfg_idx[1:0]] <= cfg_pwdata[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register file read.
  always_comb begin
    case (cfg_idx)
      omw_pkg::REG_WHEEL1_ANGLE, omw_pkg::REG_WHEEL2_ANGLE,
      omw_pkg::REG_WHEEL3_ANGLE, omw_pkg::REG_WHEEL4_ANGLE: begin
        cfg_prdata = 32'(angle_r[cfg_idx[1:0]]);
      end
      omw_pkg::REG_WHEEL1_GAIN, omw_pkg::REG_WHEEL2_GAIN,
      omw_pkg::REG_WHEEL3_GAIN, omw_pkg::REG_WHEEL4_GAIN: begin
        cfg_prdata = 32'(gain_r[cfg_idx[1:0]]);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  // Flow control: a stage advances when it is empty or the next one advances.
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_duty.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_cmd.valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load     = adv;
  assign in_cmd.ready = adv[0];
  assign out_duty.valid = vld_r[NS-1];

  // Four wheel lanes.
  assign direct[0] = in_cmd.direct_speed_1;
  assign direct[1] = in_cmd.direct_speed_2;
  assign direct[2] = in_cmd.direct_speed_3;
  assign direct[3] = in_cmd.direct_speed_4;

  for (genvar w = 0; w < NW; w++) begin : g_lane
    omw_lane u_lane (
      .clk              (clk),
      .ctl              (ctl),
      .operation        (in_cmd.operation),
      .heading          (in_cmd.heading),
      .translate_enable (in_cmd.translate_enable),
      .speed            (in_cmd.speed),
      .rotation         (in_cmd.rotation),
      .direct_speed     (direct[w]),
      .angle            (angle_r[w]),
      .gain             (gain_r[w]),
      .duty_a           (duty_a[w]),
      .duty_b           (duty_b[w])
    );
  end

  assign out_duty.duty_1a = duty_a[0];
  assign out_duty.duty_1b = duty_b[0];
  assign out_duty.duty_2a = duty_a[1];
  assign out_duty.duty_2b = duty_b[1];
  assign out_duty.duty_3a = duty_a[2];
  assign out_duty.duty_3b = duty_b[2];
  assign out_duty.duty_4a = duty_a[3];
  assign out_duty.duty_4b = duty_b[3];

  // Input back-pressure only appears when every stage is full and blocked.
  `OMW_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, !in_cmd.ready, (&vld_r) && !out_duty.ready)

  // A result that moves into the last stage shows up on the output.
  `OMW_ASSERT_NEXT(a_last_stage_fill, clk, rst_n, adv[NS-1] && vld_r[NS-2], out_duty.valid)

  // At most one channel of wheel 1 is driven below full scale.
  `OMW_ASSERT_IMPLY(a_one_side_active, clk, rst_n, out_duty.valid, out_duty.duty_1a == 8'd255 || out_duty.duty_1b == 8'd255)

endmodule
